// ===== hw/rtl/oamdma_pkg.sv =====
// Shared types and constants for the sprite DMA sequencer and clock divider.
package oamdma_pkg;

   localparam int CPU_DIVIDE_DEFAULT = 3;
   localparam int PAGE_W             = 8;
   localparam int INDEX_W            = 8;
   localparam int DATA_W             = 8;
   localparam int ADDR_W             = PAGE_W + INDEX_W;

   typedef struct packed {
      logic              dma_start;
      logic [PAGE_W-1:0] dma_page;
      logic [DATA_W-1:0] read_data;
      logic              ppu_nmi;
   } req_type;

   typedef struct packed {
      logic               ppu_enable;
      logic               cpu_enable;
      logic               read_request;
      logic [ADDR_W-1:0]  read_address;
      logic               table_write;
      logic [INDEX_W-1:0] table_address;
      logic [DATA_W-1:0]  table_data;
      logic               cpu_nmi;
      logic               dma_busy;
   } rsp_type;

endpackage

// ===== hw/rtl/oamdma_in_stage.sv =====
// Input register: holds one request until the sequencer consumes it.
module oamdma_in_stage
   import oamdma_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    held_valid,
   input  logic    held_take,
   output req_type held_data
);

   logic    valid_ff, valid_in;
   req_type data_ff;
   logic    load;

   assign req_ready = !valid_ff || held_take;
   assign load      = req_valid && req_ready;
   assign valid_in  = load || (valid_ff && !held_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= req_data;
      end
   end

   assign held_valid = valid_ff;
   assign held_data  = data_ff;

endmodule

// ===== hw/rtl/oamdma_seq.sv =====
// Divider phase, DMA state and the per-tick result logic.
module oamdma_seq
   import oamdma_pkg::*;
#(
   parameter int CPU_DIVIDE = CPU_DIVIDE_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  req_type req,
   output rsp_type rsp
);

   localparam int PHASE_W = (CPU_DIVIDE > 1) ? $clog2(CPU_DIVIDE) : 1;
   localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(CPU_DIVIDE - 1);

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic               odd_ff, odd_in;
   logic               active_ff, active_in;
   logic               aligned_ff, aligned_in;
   logic [PAGE_W-1:0]  page_ff, page_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic [DATA_W-1:0]  held_ff, held_in;
   logic               pending_ff, pending_in;

   logic               slot;
   logic               active_cur;
   logic [PAGE_W-1:0]  page_cur;
   logic [INDEX_W-1:0] index_cur;
   logic [INDEX_W-1:0] index_inc;

   always_comb begin
      // pending read data lands before anything else this tick
      held_in    = pending_ff ? req.read_data : held_ff;
      active_cur = active_ff || req.dma_start;
      page_cur   = req.dma_start ? req.dma_page : page_ff;
      index_cur  = req.dma_start ? '0 : index_ff;
      index_inc  = index_cur + INDEX_W'(1);
      slot       = (phase_ff == '0);

      active_in  = active_cur;
      aligned_in = aligned_ff;
      page_in    = page_cur;
      index_in   = index_cur;
      pending_in = 1'b0;
      odd_in     = slot ? !odd_ff : odd_ff;
      phase_in   = (phase_ff == PHASE_LAST) ? '0 : phase_ff + PHASE_W'(1);

      rsp               = '0;
      rsp.ppu_enable    = 1'b1;
      rsp.cpu_nmi       = req.ppu_nmi;
      rsp.dma_busy      = active_cur;

      if (slot) begin
         if (!active_cur) begin
            rsp.cpu_enable = 1'b1;
         end else if (!aligned_ff) begin
            aligned_in = odd_ff;
         end else if (!odd_ff) begin
            rsp.read_request = 1'b1;
            rsp.read_address = {page_cur, index_cur};
            pending_in       = 1'b1;
         end else begin
            rsp.table_write   = 1'b1;
            rsp.table_address = index_cur;
            rsp.table_data    = held_in;
            index_in          = index_inc;
            if (index_inc == '0) begin
               aligned_in = 1'b0;
               active_in  = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         odd_ff     <= 1'b0;
         active_ff  <= 1'b0;
         aligned_ff <= 1'b0;
         page_ff    <= '0;
         index_ff   <= '0;
         held_ff    <= '0;
         pending_ff <= 1'b0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         odd_ff     <= odd_in;
         active_ff  <= active_in;
         aligned_ff <= aligned_in;
         page_ff    <= page_in;
         index_ff   <= index_in;
         held_ff    <= held_in;
         pending_ff <= pending_in;
      end
   end

endmodule

// ===== hw/rtl/clock_divider_oam_dma_sequencer.sv =====
// Top level: master tick divider with sprite DMA sequencer, register in and out.
//
//   channel | ports                         | moves
//   --------+-------------------------------+------------------------------
//   req     | req_valid/req_ready + fields  | one master tick per request
//   rsp     | rsp_valid/rsp_ready + fields  | one result per request
//
// One request per clock cycle sustained while the result is not stalled; a result
// goes through the input register, then the result register.
// The DMA next-state logic feeding the state registers is combinational, which sets that rate.
// Reset clears divider phase, DMA state and both valid flags.
// A stalled result still lets one more request into the input register.
module clock_divider_oam_dma_sequencer
   import oamdma_pkg::*;
#(
   parameter int CPU_DIVIDE = CPU_DIVIDE_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_dma_start,
   input  logic [PAGE_W-1:0]  req_dma_page,
   input  logic [DATA_W-1:0]  req_read_data,
   input  logic               req_ppu_nmi,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_ppu_enable,
   output logic               rsp_cpu_enable,
   output logic               rsp_read_request,
   output logic [ADDR_W-1:0]  rsp_read_address,
   output logic               rsp_table_write,
   output logic [INDEX_W-1:0] rsp_table_address,
   output logic [DATA_W-1:0]  rsp_table_data,
   output logic               rsp_cpu_nmi,
   output logic               rsp_dma_busy
);

   req_type req_bus, held_req;
   rsp_type rsp_next, rsp_ff;
   logic    held_valid, advance, out_free;
   logic    valid_ff, valid_in;

   assign req_bus.dma_start = req_dma_start;
   assign req_bus.dma_page  = req_dma_page;
   assign req_bus.read_data = req_read_data;
   assign req_bus.ppu_nmi   = req_ppu_nmi;

   assign out_free = !valid_ff || rsp_ready;
   assign advance  = held_valid && out_free;

   oamdma_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_bus),
      .held_valid (held_valid),
      .held_take  (advance),
      .held_data  (held_req)
   );

   oamdma_seq #(
      .CPU_DIVIDE (CPU_DIVIDE)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (held_req),
      .rsp     (rsp_next)
   );

   assign valid_in = advance || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_ppu_enable    = rsp_ff.ppu_enable;
   assign rsp_cpu_enable    = rsp_ff.cpu_enable;
   assign rsp_read_request  = rsp_ff.read_request;
   assign rsp_read_address  = rsp_ff.read_address;
   assign rsp_table_write   = rsp_ff.table_write;
   assign rsp_table_address = rsp_ff.table_address;
   assign rsp_table_data    = rsp_ff.table_data;
   assign rsp_cpu_nmi       = rsp_ff.cpu_nmi;
   assign rsp_dma_busy      = rsp_ff.dma_busy;

endmodule

// ===== hw/rtl/oamdma_checker.sv =====
// Port-level checks for the sprite DMA sequencer, bound to the top level.
module oamdma_checker
   import oamdma_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_ppu_enable,
   input logic               rsp_cpu_enable,
   input logic               rsp_read_request,
   input logic [ADDR_W-1:0]  rsp_read_address,
   input logic               rsp_table_write,
   input logic               rsp_dma_busy
);

   // the processor never runs on a tick where DMA owns the bus
   a_cpu_idle_in_dma: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_cpu_enable && rsp_dma_busy))
      else $error("cpu enabled during DMA");

   a_one_bus_op: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_read_request && rsp_table_write))
      else $error("read and table write on one tick");

   a_ops_need_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_read_request || rsp_table_write) |-> rsp_dma_busy)
      else $error("DMA bus activity while not busy");

   a_addr_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_read_request |-> rsp_read_address == '0 && rsp_ppu_enable)
      else $error("stray read address or picture unit stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

endmodule

bind clock_divider_oam_dma_sequencer oamdma_checker u_oamdma_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_ppu_enable    (rsp_ppu_enable),
   .rsp_cpu_enable    (rsp_cpu_enable),
   .rsp_read_request  (rsp_read_request),
   .rsp_read_address  (rsp_read_address),
   .rsp_table_write   (rsp_table_write),
   .rsp_dma_busy      (rsp_dma_busy)
);
